// File: sv/ibpc_pkg.sv
// Package with the shared types and constants of the image blit pixel coverage block.
`timescale 1ns / 1ps

package ibpc_pkg;

  localparam int COORD_BITS  = 15;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 5;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam logic [2:0] FMT_RGB565 = 3'd0;
  localparam logic [2:0] FMT_KEYED  = 3'd1;
  localparam logic [2:0] FMT_MASKED = 3'd2;
  localparam logic [2:0] FMT_MONO1  = 3'd3;
  localparam logic [2:0] FMT_ALPHA4 = 3'd4;

  localparam logic [2:0] REG_PIXEL_FORMAT    = 3'd0;
  localparam logic [2:0] REG_FILL_COLOR      = 3'd1;
  localparam logic [2:0] REG_OPACITY         = 3'd2;
  localparam logic [2:0] REG_CHROMA_KEY      = 3'd3;
  localparam logic [2:0] REG_FLIP_MODE       = 3'd4;
  localparam logic [2:0] REG_SOURCE_WIDTH    = 3'd5;
  localparam logic [2:0] REG_SOURCE_HEIGHT   = 3'd6;
  localparam logic [2:0] REG_SOURCE_X_ORIGIN = 3'd7;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic [7:0]  data_byte;
    logic [7:0]  mask_byte;
  } in_item_t;

  typedef struct packed {
    coord_t      dest_dx;
    coord_t      dest_dy;
    coord_t      source_col;
    coord_t      source_row;
    logic [15:0] out_color;
    logic [7:0]  coverage;
    logic        draw;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [15:0] fill_color;
    logic [7:0]  opacity;
    logic [15:0] chroma_key;
    logic [1:0]  flip_mode;
    coord_t      source_width;
    coord_t      source_height;
    coord_t      source_x_origin;
  } cfg_t;

  typedef struct packed {
    coord_t      dest_dx;
    coord_t      dest_dy;
    coord_t      source_col;
    coord_t      source_row;
    logic [15:0] color;
    logic        visible;
    logic        alpha;
    logic [3:0]  nibble;
    logic        last;
  } q_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// File: sv/ibpc_regs.sv
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module ibpc_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ibpc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ibpc_pkg::cfg_t             cfg
);

  ibpc_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ibpc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format    <= ibpc_pkg::FMT_RGB565;
      cfg_r.fill_color      <= '0;
      cfg_r.opacity         <= 8'hFF;
      cfg_r.chroma_key      <= '0;
      cfg_r.flip_mode       <= '0;
      cfg_r.source_width    <= ibpc_pkg::coord_t'(1);
      cfg_r.source_height   <= ibpc_pkg::coord_t'(1);
      cfg_r.source_x_origin <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ibpc_pkg::REG_PIXEL_FORMAT:    cfg_r.pixel_format    <= pwdata[2:0];
        ibpc_pkg::REG_FILL_COLOR:      cfg_r.fill_color      <= pwdata[15:0];
        ibpc_pkg::REG_OPACITY:         cfg_r.opacity         <= pwdata[7:0];
        ibpc_pkg::REG_CHROMA_KEY:      cfg_r.chroma_key      <= pwdata[15:0];
        ibpc_pkg::REG_FLIP_MODE:       cfg_r.flip_mode       <= pwdata[1:0];
        ibpc_pkg::REG_SOURCE_WIDTH:
          cfg_r.source_width <= pwdata[ibpc_pkg::COORD_BITS-1:0];
        ibpc_pkg::REG_SOURCE_HEIGHT:
          cfg_r.source_height <= pwdata[ibpc_pkg::COORD_BITS-1:0];
        ibpc_pkg::REG_SOURCE_X_ORIGIN:
          cfg_r.source_x_origin <= pwdata[ibpc_pkg::COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ibpc_pkg::REG_PIXEL_FORMAT:    prdata = 32'(cfg_r.pixel_format);
      ibpc_pkg::REG_FILL_COLOR:      prdata = 32'(cfg_r.fill_color);
      ibpc_pkg::REG_OPACITY:         prdata = 32'(cfg_r.opacity);
      ibpc_pkg::REG_CHROMA_KEY:      prdata = 32'(cfg_r.chroma_key);
      ibpc_pkg::REG_FLIP_MODE:       prdata = 32'(cfg_r.flip_mode);
      ibpc_pkg::REG_SOURCE_WIDTH:    prdata = 32'(cfg_r.source_width);
      ibpc_pkg::REG_SOURCE_HEIGHT:   prdata = 32'(cfg_r.source_height);
      ibpc_pkg::REG_SOURCE_X_ORIGIN: prdata = 32'(cfg_r.source_x_origin);
      default:                       prdata = '0;
    endcase
  end

endmodule

// File: sv/ibpc_front.sv
// Front end: raster counters, flip and source addressing, and per-format pixel classification.
`timescale 1ns / 1ps

module ibpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ibpc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ibpc_pkg::in_item_t  in_data,
  output logic                push,
  output ibpc_pkg::q_item_t   push_data
);

  ibpc_pkg::coord_t col_cnt_r, col_cnt_nxt;
  ibpc_pkg::coord_t row_cnt_r, row_cnt_nxt;
  ibpc_pkg::coord_t w, h, wm1, hm1, rx, ry, sx;
  logic             col_end, row_end;
  logic [2:0]       bit_sel;

  assign push = in_valid && in_ready;

  always_comb begin
    w       = (cfg.source_width  == '0) ? ibpc_pkg::coord_t'(1) : cfg.source_width;
    h       = (cfg.source_height == '0) ? ibpc_pkg::coord_t'(1) : cfg.source_height;
    wm1     = w - ibpc_pkg::coord_t'(1);
    hm1     = h - ibpc_pkg::coord_t'(1);
    rx      = cfg.flip_mode[0] ? (wm1 - col_cnt_r) : col_cnt_r;
    ry      = cfg.flip_mode[1] ? (hm1 - row_cnt_r) : row_cnt_r;
    sx      = cfg.source_x_origin + rx;
    col_end = col_cnt_r >= wm1;
    row_end = row_cnt_r >= hm1;
    bit_sel = ~sx[2:0];

    push_data.dest_dx    = col_cnt_r;
    push_data.dest_dy    = row_cnt_r;
    push_data.source_col = sx;
    push_data.source_row = ry;
    push_data.last       = col_end && row_end;
    push_data.nibble     = sx[0] ? in_data.data_byte[3:0] : in_data.data_byte[7:4];
    push_data.color      = cfg.fill_color;
    push_data.visible    = 1'b1;
    push_data.alpha      = 1'b0;

    unique case (cfg.pixel_format)
      ibpc_pkg::FMT_RGB565: begin
        push_data.color = in_data.pixel_word;
      end
      ibpc_pkg::FMT_KEYED: begin
        push_data.color   = in_data.pixel_word;
        push_data.visible = in_data.pixel_word != cfg.chroma_key;
      end
      ibpc_pkg::FMT_MASKED: begin
        push_data.color   = in_data.pixel_word;
        push_data.visible = in_data.mask_byte[bit_sel];
      end
      ibpc_pkg::FMT_MONO1: begin
        push_data.visible = in_data.data_byte[bit_sel];
      end
      default: begin
        push_data.alpha = 1'b1;
      end
    endcase

    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (push) begin
      if (!col_end) begin
        col_cnt_nxt = col_cnt_r + ibpc_pkg::coord_t'(1);
      end else begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_end ? '0 : row_cnt_r + ibpc_pkg::coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

endmodule

// File: sv/ibpc_queue.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps

module ibpc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ibpc_pkg::q_item_t  push_data,
  input  logic               pop,
  output ibpc_pkg::q_item_t  pop_data,
  output ibpc_pkg::q_stat_t  stat
);

  ibpc_pkg::q_item_t                 mem_r [ibpc_pkg::QUEUE_DEPTH];
  logic [ibpc_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ibpc_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ibpc_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = count_r == '0;
  assign stat.full  = count_r == ibpc_pkg::QCNT_W'(ibpc_pkg::QUEUE_DEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + ibpc_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + ibpc_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + ibpc_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - ibpc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/ibpc_back.sv
// Back end: coverage computation, color gating and the output register.
`timescale 1ns / 1ps

module ibpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ibpc_pkg::cfg_t      cfg,
  input  ibpc_pkg::q_item_t   q_data,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ibpc_pkg::out_item_t out_data
);

  logic                valid_r, valid_nxt;
  ibpc_pkg::out_item_t data_r;
  ibpc_pkg::out_item_t res;
  logic [15:0]         prod;
  logic [16:0]         biased;
  logic [16:0]         quot;
  logic [7:0]          cov;

  assign pop       = !q_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    // Coverage of an alpha pixel is round(opacity * nibble * 17 / 255).
    prod   = 16'(cfg.opacity) * 16'({q_data.nibble, q_data.nibble});
    biased = 17'(prod) + 17'd127;
    quot   = (biased + (biased >> 8) + 17'd1) >> 8;
    if (q_data.alpha) begin
      cov = quot[7:0];
    end else begin
      cov = q_data.visible ? cfg.opacity : 8'd0;
    end

    res.dest_dx    = q_data.dest_dx;
    res.dest_dy    = q_data.dest_dy;
    res.source_col = q_data.source_col;
    res.source_row = q_data.source_row;
    res.coverage   = cov;
    res.draw       = cov != 8'd0;
    res.out_color  = res.draw ? q_data.color : 16'd0;
    res.last       = q_data.last;

    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= res;
    end
  end

endmodule

// File: sv/image_blit_pixel_coverage_top.sv
// Top level of the image blit pixel coverage block.
`timescale 1ns / 1ps

// Each request carries one fetched source pixel in destination raster order and yields one
// result with destination offsets, flipped source coordinates, color, coverage, draw and last
// flags. The block takes one request per clock while the queue is not full and holds up to four
// classified pixels in the queue between the front and back ends plus one in the output register;
// a result passes through the queue and then the output register. Rectangle counters restart
// after the last pixel. Registers are to be written only while no request is in flight.
module image_blit_pixel_coverage_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ibpc_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ibpc_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  ibpc_pkg::cfg_t    cfg;
  ibpc_pkg::q_item_t push_data;
  ibpc_pkg::q_item_t pop_data;
  ibpc_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign in_ready = !q_stat.full;

  ibpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ibpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  ibpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ibpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_data    (pop_data),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ibpc_pkg::QCNT_W'(ibpc_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_draw_matches_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.draw == (out_data.coverage != 8'd0)))
    else $error("draw flag disagrees with coverage");

  a_hidden_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.draw) |-> (out_data.out_color == 16'd0))
    else $error("color of a hidden pixel is not zero");

  a_out_drop_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn without being taken");

endmodule
